// ===== design/dlr_pkg.sv =====
`default_nettype none

package dlr_pkg;

  // Fixed-point layout of the endpoint coordinates and of the slope.
  localparam int FRAC_BITS  = 8;
  localparam int SLOPE_BITS = 16;
  localparam int COORD_W    = 24;
  localparam int CFG_W      = 12;
  localparam int COLOR_W    = 24;
  localparam int CFG_ADDR_W = 1;

  // Integer major index, wide enough to step one past the last pixel.
  localparam int IDX_W  = COORD_W - FRAC_BITS + 1;
  // Coordinate differences and the scaled index need one bit more than a coordinate.
  localparam int EXT_W  = COORD_W + 1;
  // Minor position in Q.SLOPE_BITS.
  localparam int POS_W  = 40;
  localparam int QUO_W  = SLOPE_BITS + 1;
  localparam int STEP_W = QUO_W + 1;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam int IN_DATA_W  = 4 * COORD_W + COLOR_W;
  localparam int OUT_DATA_W = 2 * CFG_W + COLOR_W;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 12'd1200;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 12'd1000;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_addr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;        // latch the endpoints and color of a start word
    logic prep;       // pick the major axis, order the endpoints, load the divider
    logic div_first;  // first divider iteration (no shift)
    logic div_run;    // one divider iteration
    logic fin;        // finish the start: store slope, emit the start result
    logic step;       // one rasterizing iteration, emit its result
  } dlr_cmd_t;

endpackage

`default_nettype wire

// ===== design/dlr_ctrl.sv =====
`default_nettype none

module dlr_ctrl
  import dlr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic     in_opcode,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output dlr_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } ctl_state_t;

  ctl_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic                 accept;

  // The output register can be loaded when empty or when its word leaves now.
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && out_free;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.cap       = accept && (in_opcode == OP_START);
    cmd.step      = accept && (in_opcode == OP_STEP);
    cmd.prep      = (state_r == ST_PREP);
    cmd.div_run   = (state_r == ST_DIV);
    cmd.div_first = (state_r == ST_DIV) && (cnt_r == '0);
    cmd.fin       = (state_r == ST_FIN) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.cap) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          state_nxt = ST_FIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.fin || cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/dlr_datapath.sv =====
`default_nettype none

module dlr_datapath
  import dlr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dlr_cmd_t              cmd,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  // True while index * 2^FRAC_BITS is below the end major coordinate.
  function automatic logic iter_ok(input logic [IDX_W-1:0] idx,
                                   input logic [COORD_W-1:0] lim);
    logic [EXT_W-1:0] scaled;
    logic [EXT_W-1:0] lim_ext;
    scaled  = {idx, {FRAC_BITS{1'b0}}};
    lim_ext = {lim[COORD_W-1], lim};
    return $signed(scaled) < $signed(lim_ext);
  endfunction

  // Configuration.
  logic [CFG_W-1:0] screen_w_r, screen_h_r;

  // Captured start word.
  logic [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COLOR_W-1:0] color_r;

  // Line state.
  logic               line_active_r, line_active_nxt;
  logic               x_major_r;
  logic [IDX_W-1:0]   index_r, index_nxt;
  logic [COORD_W-1:0] limit_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [STEP_W-1:0]  step_r;

  // Slope divider.
  logic [EXT_W-1:0]   rem_r;
  logic [COORD_W-1:0] den_r;
  logic [QUO_W-1:0]   quo_r;
  logic               neg_r;

  // Output register.
  logic [OUT_DATA_W-1:0] odata_r, odata_nxt;
  logic                  ouser_r, ouser_nxt;
  logic                  olast_r, olast_nxt;

  // Start setup.
  logic [EXT_W-1:0]   dx, dy, adx_full, ady_full;
  logic [COORD_W-1:0] adx, ady, dmaj_mag, dmin_mag;
  logic               xmaj, maj_neg, min_neg;
  logic [COORD_W-1:0] ma0, ma1, mi0;
  logic [IDX_W-1:0]   idx0;
  logic               round_up;
  logic [POS_W-1:0]   pos0;

  // Divider iteration.
  logic [EXT_W-1:0] r_sh;
  logic             ge;

  // Stepping.
  logic [CFG_W-1:0]   maj_size, min_size;
  logic [EXT_W-1:0]   idx_ext;
  logic               on_screen, has_iter, next_ok;
  logic [IDX_W-1:0]   idx_inc;
  logic [CFG_W-1:0]   pix_major, pix_minor, pix_x, pix_y;
  logic [QUO_W-1:0]   quo_sel;

  always_comb begin
    dx       = {ex_r[COORD_W-1], ex_r} - {sx_r[COORD_W-1], sx_r};
    dy       = {ey_r[COORD_W-1], ey_r} - {sy_r[COORD_W-1], sy_r};
    adx_full = dx[EXT_W-1] ? (~dx + 1'b1) : dx;
    ady_full = dy[EXT_W-1] ? (~dy + 1'b1) : dy;
    adx      = adx_full[COORD_W-1:0];
    ady      = ady_full[COORD_W-1:0];
    xmaj     = adx > ady;
    maj_neg  = xmaj ? dx[EXT_W-1] : dy[EXT_W-1];
    min_neg  = xmaj ? dy[EXT_W-1] : dx[EXT_W-1];
    dmaj_mag = xmaj ? adx : ady;
    dmin_mag = xmaj ? ady : adx;
    // A negative major delta swaps the endpoints so the major coordinate rises.
    if (xmaj) begin
      ma0 = maj_neg ? ex_r : sx_r;
      ma1 = maj_neg ? sx_r : ex_r;
      mi0 = maj_neg ? ey_r : sy_r;
    end else begin
      ma0 = maj_neg ? ey_r : sy_r;
      ma1 = maj_neg ? sy_r : ey_r;
      mi0 = maj_neg ? ex_r : sx_r;
    end
    // Division by 2^FRAC_BITS truncated toward zero.
    round_up = ma0[COORD_W-1] && (|ma0[FRAC_BITS-1:0]);
    idx0     = {{(IDX_W-(COORD_W-FRAC_BITS)){ma0[COORD_W-1]}}, ma0[COORD_W-1:FRAC_BITS]}
               + IDX_W'(round_up);
    pos0     = {{(POS_W-COORD_W){mi0[COORD_W-1]}}, mi0} << (SLOPE_BITS - FRAC_BITS);
  end

  // Restoring division of |dmin| * 2^SLOPE_BITS by |dmaj|, one quotient bit a cycle.
  // |dmin| never exceeds |dmaj|, so the first bit needs no shift.
  always_comb begin
    r_sh = cmd.div_first ? rem_r : {rem_r[EXT_W-2:0], 1'b0};
    ge   = r_sh >= {1'b0, den_r};
  end

  always_comb begin
    maj_size  = x_major_r ? screen_w_r : screen_h_r;
    min_size  = x_major_r ? screen_h_r : screen_w_r;
    idx_ext   = {{(EXT_W-IDX_W){index_r[IDX_W-1]}}, index_r};
    on_screen = !index_r[IDX_W-1] && (idx_ext < EXT_W'(maj_size)) &&
                !pos_r[POS_W-1] &&
                (pos_r[POS_W-1:SLOPE_BITS] < (POS_W-SLOPE_BITS)'(min_size));
    has_iter  = line_active_r && iter_ok(index_r, limit_r);
    idx_inc   = index_r + 1'b1;
    next_ok   = iter_ok(idx_inc, limit_r);
    pix_major = idx_ext[CFG_W-1:0];
    pix_minor = pos_r[SLOPE_BITS+CFG_W-1:SLOPE_BITS];
    pix_x     = x_major_r ? pix_major : pix_minor;
    pix_y     = x_major_r ? pix_minor : pix_major;
    quo_sel   = (den_r == '0) ? '0 : quo_r;
  end

  always_comb begin
    line_active_nxt = line_active_r;
    index_nxt       = index_r;
    pos_nxt         = pos_r;
    odata_nxt       = odata_r;
    ouser_nxt       = ouser_r;
    olast_nxt       = olast_r;
    if (cmd.prep) begin
      index_nxt = idx0;
      pos_nxt   = pos0;
    end
    if (cmd.fin) begin
      line_active_nxt = iter_ok(index_r, limit_r);
      odata_nxt       = '0;
      ouser_nxt       = 1'b0;
      olast_nxt       = !iter_ok(index_r, limit_r);
    end
    if (cmd.step) begin
      if (has_iter) begin
        odata_nxt       = on_screen ? {color_r, pix_y, pix_x} : '0;
        ouser_nxt       = on_screen;
        olast_nxt       = !next_ok;
        line_active_nxt = next_ok;
        index_nxt       = idx_inc;
        pos_nxt         = pos_r + {{(POS_W-STEP_W){step_r[STEP_W-1]}}, step_r};
      end else begin
        odata_nxt       = '0;
        ouser_nxt       = 1'b0;
        olast_nxt       = 1'b1;
        line_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r    <= SCREEN_WIDTH_RESET;
      screen_h_r    <= SCREEN_HEIGHT_RESET;
      line_active_r <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_addr == CFG_SCREEN_WIDTH))  screen_w_r <= cfg_wdata;
      if (cfg_wr_en && (cfg_addr == CFG_SCREEN_HEIGHT)) screen_h_r <= cfg_wdata;
      line_active_r <= line_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    index_r <= index_nxt;
    pos_r   <= pos_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
    if (cmd.cap) begin
      sx_r    <= in_tdata[COORD_W-1:0];
      sy_r    <= in_tdata[2*COORD_W-1:COORD_W];
      ex_r    <= in_tdata[3*COORD_W-1:2*COORD_W];
      ey_r    <= in_tdata[4*COORD_W-1:3*COORD_W];
      color_r <= in_tdata[IN_DATA_W-1:4*COORD_W];
    end
    if (cmd.prep) begin
      x_major_r <= xmaj;
      limit_r   <= ma1;
      den_r     <= dmaj_mag;
      rem_r     <= {1'b0, dmin_mag};
      quo_r     <= '0;
      neg_r     <= maj_neg ^ min_neg;
    end
    if (cmd.div_run) begin
      rem_r <= ge ? (r_sh - {1'b0, den_r}) : r_sh;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
    if (cmd.fin) begin
      step_r <= neg_r ? (~{1'b0, quo_sel} + 1'b1) : {1'b0, quo_sel};
    end
  end

  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;
  assign out_tlast = olast_r;

endmodule

`default_nettype wire

// ===== design/dda_line_rasterizer_core.sv =====
// DDA line rasterizer. A start word (tuser 0) brings two signed Q16.8 endpoints and a
// color; each step word (tuser 1) walks one pixel along the major axis and returns one
// result word whose tuser flags an on-screen pixel and whose tlast marks the end of the
// line. Every input word yields exactly one result word. Steps stream one per cycle while
// the result side keeps up. A start word occupies the block through these steps in order:
// capture, setup of the major axis and endpoint order, the restoring slope divider that
// produces one quotient bit a cycle, and loading of the start result. The result sits in
// an output register, so the next word is taken in the same cycle that the previous
// result leaves.
`default_nettype none

module dda_line_rasterizer_core
  import dlr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // start_x, start_y, end_x, end_y, red, green, blue
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // pixel_valid
  output logic                       out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  dlr_cmd_t cmd;

  dlr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dlr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // A new word is only taken when its result has a free output register.
  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input taken while output register is blocked");

  // A result that writes no pixel carries zero pixel fields.
  a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("pixel fields nonzero without a pixel");

  // A step result is presented in the cycle after the step word is taken.
  a_step_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_STEP)) |=> out_tvalid)
    else $error("step result missing");

  // A start word holds off new input while the slope is computed.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_START)) |=> (!in_tready && !out_tvalid))
    else $error("start word did not occupy the block");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_dda_line_rasterizer_core.sv =====
`timescale 1ns / 1ps

module tb_dda_line_rasterizer_core;
  import dlr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  // A start word keeps the block busy while its slope is computed.
  localparam int SETTLE_CYCLES = 24;
  localparam longint MAJ_ONE = longint'(1) << FRAC_BITS;
  localparam longint MIN_ONE = longint'(1) << SLOPE_BITS;

  // Packed so that the result word maps onto {tlast, tuser, tdata}.
  typedef struct packed {
    logic       finished;
    logic       pixel_valid;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
  } raster_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = OP_START;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  cfg_addr_t cfg_addr = CFG_SCREEN_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  dda_line_rasterizer_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Rasterizer state as the block should hold it.
  logic        ln_active = 1'b0;
  logic        ln_x_major = 1'b0;
  longint      ln_index = 0;
  longint      ln_limit = 0;
  longint      ln_minor = 0;
  longint      ln_slope = 0;
  logic [23:0] ln_color = '0;
  logic [CFG_W-1:0] scr_w = SCREEN_WIDTH_RESET;
  logic [CFG_W-1:0] scr_h = SCREEN_HEIGHT_RESET;

  raster_result_t pending_pixels[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int words_sent = 0;
  int lines_started = 0;
  int results_seen = 0;
  int pixels_drawn = 0;
  int errors = 0;

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit line_has_pixel();
    return ln_active && (ln_index * MAJ_ONE < ln_limit);
  endfunction

  function automatic raster_result_t predict_pixel(opcode_t op, logic [IN_DATA_W-1:0] data);
    raster_result_t res;
    longint x0, y0, x1, y1, ma0, ma1, mi0, mi1, t, major_size, minor_size, mi;
    res = '0;
    if (op == OP_START) begin
      x0 = longint'($signed(data[23:0]));
      y0 = longint'($signed(data[47:24]));
      x1 = longint'($signed(data[71:48]));
      y1 = longint'($signed(data[95:72]));
      ln_x_major = abs_l(x1 - x0) > abs_l(y1 - y0);
      if (ln_x_major) begin
        ma0 = x0; ma1 = x1; mi0 = y0; mi1 = y1;
      end else begin
        ma0 = y0; ma1 = y1; mi0 = x0; mi1 = x1;
      end
      if (ma0 > ma1) begin
        t = ma0; ma0 = ma1; ma1 = t;
        t = mi0; mi0 = mi1; mi1 = t;
      end
      ln_slope = (ma1 != ma0) ? ((mi1 - mi0) * MIN_ONE) / (ma1 - ma0) : 0;
      ln_index = ma0 / MAJ_ONE;
      ln_limit = ma1;
      ln_minor = mi0 * (MIN_ONE / MAJ_ONE);
      ln_color = {data[103:96], data[111:104], data[119:112]};
      ln_active = 1'b1;
      ln_active = line_has_pixel();
      res.finished = !ln_active;
    end else if (!line_has_pixel()) begin
      ln_active = 1'b0;
      res.finished = 1'b1;
    end else begin
      major_size = ln_x_major ? longint'(scr_w) : longint'(scr_h);
      minor_size = ln_x_major ? longint'(scr_h) : longint'(scr_w);
      if (ln_index >= 0 && ln_index < major_size &&
          ln_minor >= 0 && ln_minor < minor_size * MIN_ONE) begin
        mi = ln_minor / MIN_ONE;
        res.pixel_x = ln_x_major ? ln_index[11:0] : mi[11:0];
        res.pixel_y = ln_x_major ? mi[11:0] : ln_index[11:0];
        res.pixel_red = ln_color[23:16];
        res.pixel_green = ln_color[15:8];
        res.pixel_blue = ln_color[7:0];
        res.pixel_valid = 1'b1;
      end
      // The minor position moves on even when the pixel is off screen.
      ln_minor += ln_slope;
      ln_index += 1;
      ln_active = line_has_pixel();
      res.finished = !ln_active;
    end
    return res;
  endfunction

  function automatic logic [IN_DATA_W-1:0] line_word(int sx, int sy, int ex, int ey,
                                                     logic [23:0] rgb);
    return {rgb[7:0], rgb[15:8], rgb[23:16], ey[23:0], ex[23:0], sy[23:0], sx[23:0]};
  endfunction

  // Step words ignore their data, so it is filled with noise.
  function automatic logic [IN_DATA_W-1:0] filler();
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    return noise[IN_DATA_W-1:0];
  endfunction

  function automatic int rand_near(int size);
    return int'($urandom_range(0, (size + 24) * 256)) - 12 * 256;
  endfunction

  task automatic send_word(opcode_t op, logic [IN_DATA_W-1:0] data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    pending_pixels.insert(pending_pixels.size(), predict_pixel(op, data));
    words_sent++;
    if (op == OP_START) lines_started++;
  endtask

  task automatic draw_line(int sx, int sy, int ex, int ey, logic [23:0] rgb, int max_steps);
    int n;
    n = 0;
    send_word(OP_START, line_word(sx, sy, ex, ey, rgb));
    while (ln_active && n < max_steps) begin
      send_word(OP_STEP, filler());
      n++;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scr_w = w;
    scr_h = h;
  endtask

  task automatic random_line();
    int kind, sx, sy, ex, ey, d, max_steps;
    kind = $urandom_range(15);
    sx = rand_near(int'(scr_w));
    sy = rand_near(int'(scr_h));
    ex = sx + int'($urandom_range(0, 80 * 256)) - 40 * 256;
    ey = sy + int'($urandom_range(0, 80 * 256)) - 40 * 256;
    max_steps = 200;
    case (kind)
      0: begin
        ex = sx;
        ey = sy;
      end
      1: begin
        // Equal spans: y wins the major axis.
        d = ex - sx;
        ey = $urandom_range(1) ? sy + d : sy - d;
      end
      2: begin
        sx = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        sy = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        ex = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        ey = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        max_steps = $urandom_range(0, 8);
      end
      3: max_steps = $urandom_range(0, 5);
      default: ;
    endcase
    if (kind == 4) begin
      repeat ($urandom_range(1, 3)) send_word(OP_STEP, filler());
    end else begin
      draw_line(sx, sy, ex, ey, 24'($urandom), max_steps);
      if ($urandom_range(3) == 0) send_word(OP_STEP, filler());
    end
  endtask

  task automatic run_random_lines(int words);
    int target;
    target = words_sent + words;
    while (words_sent < target) random_line();
  endtask

  task automatic test_directed_lines();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(OP_STEP, filler());
    // Full-range x span: the index starts far left of the screen.
    draw_line(-8388608, 0, 8388607, 0, 24'hFFFFFF, 2);
    // Full-range diagonal drawn backwards.
    draw_line(8388607, 8388607, -8388608, -8388608, 24'h000000, 1);
    draw_line(10 * 256 + 128, 10 * 256 + 128, 10 * 256 + 128, 10 * 256 + 128, 24'h123456, 4);
    send_word(OP_STEP, filler());
    // Starts off screen in both axes and enters at x = 4, then is cut off by a new start.
    draw_line(-2 * 256, -3 * 256, 6 * 256, 1 * 256, 24'h80C040, 7);
    draw_line(1198 * 256 + 128, 998 * 256 + 64, 1202 * 256, 1000 * 256 + 192, 24'hFF00FF, 10);
    send_word(OP_STEP, filler());
    draw_line(-1 * 256 - 128, 3 * 256, 1 * 256 + 64, -128, 24'h00FF00, 10);
  endtask

  task automatic test_screen_limits();
    wait_drained();
    write_screen(12'd4095, 12'd4095);
    draw_line(4092 * 256, 100 * 256, 4097 * 256 + 200, 103 * 256, 24'hA5A5A5, 10);
    draw_line(7 * 256, 4093 * 256, 8 * 256, 4097 * 256, 24'h5A5A5A, 10);
    wait_drained();
    write_screen(12'd1, 12'd1);
    draw_line(0, 0, 3 * 256, 3 * 256, 24'hC0FFEE, 10);
    wait_drained();
    // A zero size hides every pixel while the line still steps.
    write_screen(12'd0, 12'd0);
    draw_line(0, 0, 3 * 256, 256, 24'h0F0F0F, 10);
    wait_drained();
    write_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 400;
    repeat (8) random_line();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 25;
    recv_idle_pct = 73;
    run_random_lines(540);
    wait_drained();
    write_screen(12'd64, 12'd48);
    send_idle_pct = 73;
    recv_idle_pct = 25;
    run_random_lines(540);
    wait_drained();
    write_screen(CFG_W'($urandom_range(1, 320)), CFG_W'($urandom_range(1, 320)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_lines(540);
  endtask

  always @(posedge clk) begin : result_checker
    raster_result_t got, want;
    if (out_tvalid && out_tready) begin
      got = raster_result_t'({out_tlast, out_tuser, out_tdata});
      results_seen++;
      if (got.pixel_valid) pixels_drawn++;
      if (pending_pixels.size() == 0) begin
        $error("result word with no input word waiting for it");
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
          errors++;
        end
        if (got.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
          errors++;
        end
        if (got.pixel_red !== want.pixel_red) begin
          $error("pixel_red: expected %0d, got %0d", want.pixel_red, got.pixel_red);
          errors++;
        end
        if (got.pixel_green !== want.pixel_green) begin
          $error("pixel_green: expected %0d, got %0d", want.pixel_green, got.pixel_green);
          errors++;
        end
        if (got.pixel_blue !== want.pixel_blue) begin
          $error("pixel_blue: expected %0d, got %0d", want.pixel_blue, got.pixel_blue);
          errors++;
        end
        if (got.pixel_valid !== want.pixel_valid) begin
          $error("pixel_valid: expected %0d, got %0d", want.pixel_valid, got.pixel_valid);
          errors++;
        end
        if (got.finished !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, got.finished);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_lines();
    test_screen_limits();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    $display("Sent %0d words (%0d line starts); checked %0d result words, %0d on-screen pixels.",
             words_sent, lines_started, results_seen, pixels_drawn);
    $display("Screens from 0x0 to 4095x4095, idling on both sides and a long result stall.");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
